// ===== rtl/imrsz_pkg.sv =====
// ----------------------------------------------------------------------------
// imrsz_pkg
// Shared types and constants of the image resize unit: field widths,
// fixed-point constants, register indexes and divider request/response.
// ----------------------------------------------------------------------------
package imrsz_pkg;

    // Field and register widths
    localparam int SIZE_W = 9;
    localparam int CRD_W  = 8;
    localparam int CH_W   = 2;
    localparam int SMP_W  = 8;
    localparam int RES_W  = 16;
    localparam int CCNT_W = 2;
    localparam int CIDX_W = 3;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_CHANNELS   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_FILTER     = 3'd5;

    // Command and filter codes
    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_READ      = 1'b1;
    localparam logic FILT_NEAREST  = 1'b0;
    localparam logic FILT_TRIANGLE = 1'b1;

    // Fixed-point constants: Q9.16 positions, Q1.15 weights
    localparam int Q_ONE  = 65536;
    localparam int Q_HALF = 32768;
    localparam int W_ONE  = 32768;
    localparam int FRAC_W = 16;

    // Datapath widths (sizes up to 511)
    localparam int POS_W  = 25;   // Q9.16 position / window
    localparam int SPOS_W = 28;   // signed center and window ends
    localparam int TAP_W  = 12;   // signed tap index
    localparam int WT_W   = 16;   // tap weight, up to 1.0 in Q1.15
    localparam int WT_AW  = 9;    // weight table index
    localparam int WT_DEPTH = 512;
    localparam int TOT_W  = 24;   // weight sum
    localparam int HACC_W = 32;   // horizontal accumulator

    // Serial divider
    localparam int DIV_NW = 40;
    localparam int DIV_DW = 25;
    localparam int DIV_CW = 6;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/imrsz_frame_mem.sv =====
// ----------------------------------------------------------------------------
// imrsz_frame_mem
// Source frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module imrsz_frame_mem #(
    parameter int DEPTH = 196608,
    parameter int AW    = 18
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [imrsz_pkg::SMP_W-1:0]   i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [imrsz_pkg::SMP_W-1:0]   o_rdata
);

    logic [imrsz_pkg::SMP_W-1:0] r_mem [DEPTH];
    logic [imrsz_pkg::SMP_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/imrsz_div.sv =====
// ----------------------------------------------------------------------------
// imrsz_div
// Restoring divider, one quotient bit per cycle; done pulses for one cycle
// with the quotient valid.
// ----------------------------------------------------------------------------
module imrsz_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  imrsz_pkg::t_div_req i_req,
    output imrsz_pkg::t_div_rsp o_rsp
);

    localparam int NW = imrsz_pkg::DIV_NW;
    localparam int DW = imrsz_pkg::DIV_DW;
    localparam int CW = imrsz_pkg::DIV_CW;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // One restoring step
    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

// ===== rtl/image_resize_nearest_or_triangle_unit.sv =====
// ----------------------------------------------------------------------------
// image_resize_nearest_or_triangle_unit
// Separable nearest / triangle image resizer over a stored 8-bit HWC frame.
// ----------------------------------------------------------------------------
// A write transfer stores one source sample. A read transfer
// works on one item at a time through a sequencer around the frame memory
// and a serial divider. Each pass set-up costs up to two divisions
// (position, and in triangle mode the window when shrinking); in triangle
// mode every horizontal tap weight costs one division, then each vertical
// tap costs one weight division, a sweep through the frame memory of one
// horizontal tap per cycle and a normalizing division; one more division
// ends the item. A tap outside the window skips its division, and a pass
// with equal sizes skips its position division. The finished result
// waits in its own register, so a stalled result never changes. The frame
// memory has no reset and needs no clearing pass; reading an unwritten
// sample gives an undefined value.
// ----------------------------------------------------------------------------
module image_resize_nearest_or_triangle_unit #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [imrsz_pkg::CRD_W-1:0]     i_row,
    input  logic [imrsz_pkg::CRD_W-1:0]     i_col,
    input  logic [imrsz_pkg::CH_W-1:0]      i_chan,
    input  logic [imrsz_pkg::SMP_W-1:0]     i_sample_in,
    // result item
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [imrsz_pkg::RES_W-1:0]     o_sample_out,
    output logic                            o_out_of_range,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [imrsz_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [imrsz_pkg::SIZE_W-1:0]    i_cfg_data
);

    localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int SW  = imrsz_pkg::SIZE_W;
    localparam int TW  = imrsz_pkg::TAP_W;
    localparam int PW  = imrsz_pkg::POS_W;
    localparam int SPW = imrsz_pkg::SPOS_W;
    localparam int NW  = imrsz_pkg::DIV_NW;
    localparam int DW  = imrsz_pkg::DIV_DW;
    localparam int WW  = imrsz_pkg::WT_W;
    localparam int TOW = imrsz_pkg::TOT_W;
    localparam int HW  = imrsz_pkg::HACC_W;
    localparam int RW  = imrsz_pkg::RES_W;
    localparam int FW  = imrsz_pkg::FRAC_W;

    // Sequencer states
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_POS      = 5'd1;
    localparam logic [4:0] S_POS_WAIT = 5'd2;
    localparam logic [4:0] S_WIN_WAIT = 5'd3;
    localparam logic [4:0] S_WINDOW   = 5'd4;
    localparam logic [4:0] S_SETDONE  = 5'd5;
    localparam logic [4:0] S_TW       = 5'd6;
    localparam logic [4:0] S_TW_WAIT  = 5'd7;
    localparam logic [4:0] S_VNEXT    = 5'd8;
    localparam logic [4:0] S_ROW_INIT = 5'd9;
    localparam logic [4:0] S_ROW_RD   = 5'd10;
    localparam logic [4:0] S_ROW_DIV  = 5'd11;
    localparam logic [4:0] S_ROW_WAIT = 5'd12;
    localparam logic [4:0] S_ROW_ACC  = 5'd13;
    localparam logic [4:0] S_FIN      = 5'd14;
    localparam logic [4:0] S_FIN_WAIT = 5'd15;
    localparam logic [4:0] S_OUT      = 5'd16;

    // Configuration registers
    logic [SW-1:0]                   r_src_width, r_src_height;
    logic [SW-1:0]                   r_dst_width, r_dst_height;
    logic [imrsz_pkg::CCNT_W-1:0]    r_channels;
    logic                            r_filter;

    // Sequencer registers
    logic [4:0]                      r_state, n_state;
    logic [imrsz_pkg::CRD_W-1:0]     r_row, n_row, r_col, n_col;
    logic [imrsz_pkg::CH_W-1:0]      r_chan, n_chan;
    logic                            r_pass, n_pass;
    logic [PW-1:0]                   r_pos, n_pos, r_w, n_w;
    logic signed [SPW-1:0]           r_c, n_c;
    logic signed [TW-1:0]            r_sf, n_sf, r_sl, n_sl;
    logic                            r_su, n_su;
    logic signed [TW-1:0]            r_t, n_t;
    logic signed [TW-1:0]            r_h_first, n_h_first, r_h_last, n_h_last;
    logic signed [TW-1:0]            r_v_t, n_v_t, r_v_last, n_v_last;
    logic signed [TW-1:0]            r_ht, n_ht;
    logic [TOW-1:0]                  r_htot, n_htot, r_vtot, n_vtot;
    logic [HW-1:0]                   r_hacc, n_hacc;
    logic [NW-1:0]                   r_vacc, n_vacc;
    logic [WW-1:0]                   r_vw, n_vw;
    logic [RW-1:0]                   r_h, n_h;
    logic                            r_rd_vld, n_rd_vld;
    logic [RW-1:0]                   r_calc, n_calc;
    logic                            r_coor, n_coor;

    // Output register
    logic                            r_out_valid, n_out_valid;
    logic [RW-1:0]                   r_res, n_res;
    logic                            r_oor, n_oor;

    // Weight table
    logic [WW-1:0]                   r_wmem [imrsz_pkg::WT_DEPTH];
    logic [WW-1:0]                   r_wdata;
    logic                            wt_we;
    logic [imrsz_pkg::WT_AW-1:0]     wt_waddr;
    logic [WW-1:0]                   wt_wdata;

    // Frame memory ports
    logic                            fm_we;
    logic [AW-1:0]                   fm_waddr, fm_raddr;
    logic [imrsz_pkg::SMP_W-1:0]     fm_rdata;

    // Divider
    imrsz_pkg::t_div_req             div_req;
    imrsz_pkg::t_div_rsp             div_rsp;

    // Clamped sizes
    logic [SW-1:0]                   sw, sh, dw, dh;
    logic [imrsz_pkg::CCNT_W-1:0]    cc;

    // Per-pass selection
    logic [SW-1:0]                   p_d, p_s, p_n;
    logic [SW+SW:0]                  pos_prod;

    logic in_acc;
    logic out_acc;
    logic cfg_acc;

    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v, input int hi);
        logic [SW-1:0] r;
        if (v == '0) begin
            r = SW'(1);
        end else if (int'(v) > hi) begin
            r = SW'(hi);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Handshakes
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_acc     = r_out_valid && !i_out_stall;
    assign cfg_acc     = i_cfg_valid;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Effective configuration
    always_comb begin
        sw = clamp_size(r_src_width,  MAX_WIDTH);
        sh = clamp_size(r_src_height, MAX_HEIGHT);
        dw = clamp_size(r_dst_width,  MAX_WIDTH);
        dh = clamp_size(r_dst_height, MAX_HEIGHT);
        if (r_channels == '0) begin
            cc = imrsz_pkg::CCNT_W'(1);
        end else if (int'(r_channels) > MAX_CHANNELS) begin
            cc = imrsz_pkg::CCNT_W'(MAX_CHANNELS);
        end else begin
            cc = r_channels;
        end
    end

    // Select horizontal or vertical pass operands
    always_comb begin
        p_d      = r_pass ? {1'b0, r_row} : {1'b0, r_col};
        p_s      = r_pass ? sh : sw;
        p_n      = r_pass ? dh : dw;
        pos_prod = {p_d, 1'b1} * p_s;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SW'(1);
            r_src_height <= SW'(1);
            r_dst_width  <= SW'(1);
            r_dst_height <= SW'(1);
            r_channels   <= imrsz_pkg::CCNT_W'(3);
            r_filter     <= imrsz_pkg::FILT_NEAREST;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                imrsz_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                imrsz_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                imrsz_pkg::CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                imrsz_pkg::CFG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                imrsz_pkg::CFG_CHANNELS:   r_channels   <= i_cfg_data[imrsz_pkg::CCNT_W-1:0];
                imrsz_pkg::CFG_FILTER:     r_filter     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Source sample writes go straight to the frame memory
    always_comb begin
        fm_we    = in_acc && (i_command == imrsz_pkg::CMD_WRITE)
                   && (int'(i_row) < MAX_HEIGHT) && (int'(i_col) < MAX_WIDTH)
                   && (int'(i_chan) < MAX_CHANNELS);
        fm_waddr = AW'((int'(i_row) * MAX_WIDTH + int'(i_col)) * MAX_CHANNELS
                       + int'(i_chan));
        fm_raddr = AW'((int'(r_v_t[SW-1:0]) * MAX_WIDTH + int'(r_ht[SW-1:0]))
                       * MAX_CHANNELS + int'(r_chan));
    end

    imrsz_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_frame_mem (
        .i_clk   (i_clk),
        .i_we    (fm_we),
        .i_waddr (fm_waddr),
        .i_wdata (i_sample_in),
        .i_raddr (fm_raddr),
        .o_rdata (fm_rdata)
    );

    imrsz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Weight table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wt_we) begin
            r_wmem[wt_waddr] <= wt_wdata;
        end
        r_wdata <= r_wmem[r_ht[imrsz_pkg::WT_AW-1:0]];
    end

    // Sequencer
    always_comb begin
        logic [SW-1:0]         qi;
        logic [SW-1:0]         idx;
        logic signed [SPW-1:0] c, wv, lo, hi, a, b, smax;
        logic signed [TW-1:0]  tap;
        logic signed [SPW-1:0] diff, tap_dist;
        logic                  tw_take;
        logic [WW-1:0]         wt;

        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_chan      = r_chan;
        n_pass      = r_pass;
        n_pos       = r_pos;
        n_w         = r_w;
        n_c         = r_c;
        n_sf        = r_sf;
        n_sl        = r_sl;
        n_su        = r_su;
        n_t         = r_t;
        n_h_first   = r_h_first;
        n_h_last    = r_h_last;
        n_v_t       = r_v_t;
        n_v_last    = r_v_last;
        n_ht        = r_ht;
        n_htot      = r_htot;
        n_vtot      = r_vtot;
        n_vacc      = r_vacc;
        n_vw        = r_vw;
        n_h         = r_h;
        n_rd_vld    = 1'b0;
        n_calc      = r_calc;
        n_coor      = r_coor;
        n_res       = r_res;
        n_oor       = r_oor;
        n_out_valid = out_acc ? 1'b0 : r_out_valid;
        // accumulate the tap read issued last cycle
        n_hacc      = r_rd_vld ? r_hacc + HW'(r_wdata) * HW'(fm_rdata) : r_hacc;

        div_req     = '0;
        wt_we       = 1'b0;
        wt_waddr    = r_t[imrsz_pkg::WT_AW-1:0];
        wt_wdata    = '0;

        qi   = div_rsp.quot[PW-1:FW];
        idx  = (qi >= p_s) ? p_s - 1'b1 : qi;
        c    = $signed({{(SPW-PW){1'b0}}, r_pos}) - $signed(SPW'(imrsz_pkg::Q_HALF));
        wv   = $signed({{(SPW-PW){1'b0}}, r_w});
        lo   = c - wv;
        hi   = c + wv;
        a    = (lo + $signed(SPW'(imrsz_pkg::Q_ONE - 1))) >>> FW;
        b    = hi >>> FW;
        smax = $signed(SPW'(p_s)) - $signed(SPW'(1));
        tap  = r_pass ? r_v_t : r_t;
        diff = $signed({tap, {FW{1'b0}}}) - r_c;
        tap_dist = diff[SPW-1] ? -diff : diff;
        tw_take = 1'b0;
        wt      = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_command == imrsz_pkg::CMD_READ)) begin
                    n_row  = i_row;
                    n_col  = i_col;
                    n_chan = i_chan;
                    n_pass = 1'b0;
                    if (({1'b0, i_row} >= dh) || ({1'b0, i_col} >= dw) || (i_chan >= cc)) begin
                        n_calc  = '0;
                        n_coor  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_coor  = 1'b0;
                        n_state = S_POS;
                    end
                end
            end
            // source position of the pass
            S_POS: begin
                if (p_s == p_n) begin
                    n_sf    = $signed(TW'(p_d));
                    n_sl    = $signed(TW'(p_d));
                    n_su    = 1'b1;
                    n_state = S_SETDONE;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = NW'({pos_prod, {FW{1'b0}}});
                    div_req.den   = DW'({p_n, 1'b0});
                    n_state       = S_POS_WAIT;
                end
            end
            S_POS_WAIT: begin
                if (div_rsp.done) begin
                    n_pos = div_rsp.quot[PW-1:0];
                    if (r_filter == imrsz_pkg::FILT_NEAREST) begin
                        n_sf    = $signed(TW'(idx));
                        n_sl    = $signed(TW'(idx));
                        n_su    = 1'b1;
                        n_state = S_SETDONE;
                    end else if (p_s >= p_n) begin
                        div_req.start = 1'b1;
                        div_req.num   = NW'({p_s, {FW{1'b0}}});
                        div_req.den   = DW'(p_n);
                        n_state       = S_WIN_WAIT;
                    end else begin
                        n_w     = PW'(imrsz_pkg::Q_ONE);
                        n_state = S_WINDOW;
                    end
                end
            end
            S_WIN_WAIT: begin
                if (div_rsp.done) begin
                    n_w     = div_rsp.quot[PW-1:0];
                    n_state = S_WINDOW;
                end
            end
            // tap range of the triangle window, clipped to the frame
            S_WINDOW: begin
                if (a >= b) begin
                    a = c >>> FW;
                    b = (c + $signed(SPW'(imrsz_pkg::Q_ONE - 1))) >>> FW;
                end
                if (a < 0) begin
                    a = '0;
                end
                if (b > smax) begin
                    b = smax;
                end
                n_c     = c;
                n_sf    = a[TW-1:0];
                n_sl    = b[TW-1:0];
                n_su    = 1'b0;
                n_state = S_SETDONE;
            end
            S_SETDONE: begin
                if (!r_pass) begin
                    n_h_first = r_sf;
                    n_h_last  = r_sl;
                    n_htot    = '0;
                    n_t       = r_sf;
                    if (r_su) begin
                        wt_we    = 1'b1;
                        wt_waddr = r_sf[imrsz_pkg::WT_AW-1:0];
                        wt_wdata = WW'(1);
                        n_htot   = TOW'(1);
                        n_pass   = 1'b1;
                        n_state  = S_POS;
                    end else begin
                        n_state = S_TW;
                    end
                end else begin
                    n_v_t    = r_sf;
                    n_v_last = r_sl;
                    n_vacc   = '0;
                    n_vtot   = '0;
                    n_state  = S_VNEXT;
                end
            end
            // tap weight: 1.0 minus distance over window
            S_TW: begin
                if (!r_pass && (r_t > r_h_last)) begin
                    n_pass  = 1'b1;
                    n_state = S_POS;
                end else if (tap_dist >= wv) begin
                    tw_take = 1'b1;
                    wt      = '0;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = NW'({tap_dist[PW-1:0], {(FW-1){1'b0}}});
                    div_req.den   = DW'(r_w);
                    n_state       = S_TW_WAIT;
                end
            end
            S_TW_WAIT: begin
                if (div_rsp.done) begin
                    tw_take = 1'b1;
                    wt      = WW'(imrsz_pkg::W_ONE) - div_rsp.quot[WW-1:0];
                end
            end
            S_VNEXT: begin
                if (r_v_t > r_v_last) begin
                    n_state = S_FIN;
                end else if (r_su) begin
                    n_vw    = WW'(1);
                    n_vtot  = r_vtot + TOW'(1);
                    n_state = S_ROW_INIT;
                end else begin
                    n_state = S_TW;
                end
            end
            S_ROW_INIT: begin
                n_ht    = r_h_first;
                n_hacc  = '0;
                n_state = S_ROW_RD;
            end
            // sweep the horizontal taps of one source row
            S_ROW_RD: begin
                if (r_ht <= r_h_last) begin
                    n_rd_vld = 1'b1;
                    n_ht     = r_ht + 1'b1;
                end else begin
                    n_state = S_ROW_DIV;
                end
            end
            S_ROW_DIV: begin
                if (r_htot == '0) begin
                    n_h     = '0;
                    n_state = S_ROW_ACC;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = NW'({r_hacc, 8'h00});
                    div_req.den   = DW'(r_htot);
                    n_state       = S_ROW_WAIT;
                end
            end
            S_ROW_WAIT: begin
                if (div_rsp.done) begin
                    n_h     = div_rsp.quot[RW-1:0];
                    n_state = S_ROW_ACC;
                end
            end
            S_ROW_ACC: begin
                n_vacc  = r_vacc + NW'(r_vw) * NW'(r_h);
                n_v_t   = r_v_t + 1'b1;
                n_state = S_VNEXT;
            end
            S_FIN: begin
                if (r_vtot == '0) begin
                    n_calc  = '0;
                    n_state = S_OUT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = r_vacc;
                    div_req.den   = DW'(r_vtot);
                    n_state       = S_FIN_WAIT;
                end
            end
            S_FIN_WAIT: begin
                if (div_rsp.done) begin
                    n_calc  = div_rsp.quot[RW-1:0];
                    n_state = S_OUT;
                end
            end
            // hand the result to the output register once it is free
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_res       = r_calc;
                    n_oor       = r_coor;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // store a finished tap weight
        if (tw_take) begin
            if (!r_pass) begin
                wt_we    = 1'b1;
                wt_waddr = r_t[imrsz_pkg::WT_AW-1:0];
                wt_wdata = wt;
                n_htot   = r_htot + TOW'(wt);
                n_t      = r_t + 1'b1;
                n_state  = S_TW;
            end else begin
                n_vw   = wt;
                n_vtot = r_vtot + TOW'(wt);
                if (wt == '0) begin
                    n_v_t   = r_v_t + 1'b1;
                    n_state = S_VNEXT;
                end else begin
                    n_state = S_ROW_INIT;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_col     <= n_col;
        r_chan    <= n_chan;
        r_pass    <= n_pass;
        r_pos     <= n_pos;
        r_w       <= n_w;
        r_c       <= n_c;
        r_sf      <= n_sf;
        r_sl      <= n_sl;
        r_su      <= n_su;
        r_t       <= n_t;
        r_h_first <= n_h_first;
        r_h_last  <= n_h_last;
        r_v_t     <= n_v_t;
        r_v_last  <= n_v_last;
        r_ht      <= n_ht;
        r_htot    <= n_htot;
        r_vtot    <= n_vtot;
        r_hacc    <= n_hacc;
        r_vacc    <= n_vacc;
        r_vw      <= n_vw;
        r_h       <= n_h;
        r_calc    <= n_calc;
        r_coor    <= n_coor;
        r_res     <= n_res;
        r_oor     <= n_oor;
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = r_res;
    assign o_out_of_range = r_oor;

endmodule
